[hw/rtl/pbr_pkg.sv]
// ----------------------------------------------------------------------------
// pbr_pkg
// Shared types and codes of the partition block refiner: operation and status
// codes, register index, phase encoding and the result record.
// ----------------------------------------------------------------------------
package pbr_pkg;

   localparam int DEF_MAX_STATES = 64;
   localparam int RESULT_CAP     = 32;

   // operation codes
   localparam logic [2:0] OP_CLEAR  = 3'd0;
   localparam logic [2:0] OP_LOAD   = 3'd1;
   localparam logic [2:0] OP_FINISH = 3'd2;
   localparam logic [2:0] OP_MARK   = 3'd3;
   localparam logic [2:0] OP_SPLIT  = 3'd4;
   localparam logic [2:0] OP_QUERY  = 3'd5;

   // status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_RANGE = 2'd1;
   localparam logic [1:0] ST_DUP   = 2'd2;
   localparam logic [1:0] ST_PHASE = 2'd3;

   // register index
   localparam logic REG_NUM_STATES = 1'b0;

   typedef enum logic [1:0] {
      PH_IDLE  = 2'd0,
      PH_OPEN  = 2'd1,
      PH_READY = 2'd2
   } phase_type;

   typedef struct packed {
      logic [1:0] status;
      logic [5:0] block_of_state;
      logic [5:0] block_of_other;
      logic       same_block;
      logic       split_valid;
      logic [5:0] kept_block;
      logic [5:0] new_block;
      logic [6:0] ancestor_node;
      logic       last;
   } rsp_type;

endpackage

[hw/rtl/pbr_ctrl.sv]
// ----------------------------------------------------------------------------
// pbr_ctrl
// Sequencer of the partition block refiner with its six state memories.
// ----------------------------------------------------------------------------
module pbr_ctrl #(
   parameter int MAX_STATES = pbr_pkg::DEF_MAX_STATES
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [6:0]       num_states,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [2:0]       req_operation,
   input  logic [5:0]       req_state_id,
   input  logic [5:0]       req_other_state_id,
   input  logic             req_end_of_block,
   output logic             res_push,
   output pbr_pkg::rsp_type res_data,
   input  logic             res_free
);

   localparam int IW  = $clog2(MAX_STATES);
   localparam int CW  = IW + 1;
   localparam int ND  = 2 * MAX_STATES - 1;
   localparam int NW  = $clog2(ND);
   localparam int NCW = NW + 1;
   localparam int EW  = (CW > 7) ? CW : 7;

   typedef enum logic [22:0] {
      S_IDLE    = 23'd1 << 0,
      S_DISP    = 23'd1 << 1,
      S_EMIT    = 23'd1 << 2,
      S_FIN     = 23'd1 << 3,
      S_QA      = 23'd1 << 4,
      S_QB      = 23'd1 << 5,
      S_QC      = 23'd1 << 6,
      S_SP_BLK  = 23'd1 << 7,
      S_SP_NODE = 23'd1 << 8,
      S_SP_RNG  = 23'd1 << 9,
      S_CNT_RD  = 23'd1 << 10,
      S_CNT_EV  = 23'd1 << 11,
      S_A_RD    = 23'd1 << 12,
      S_A_EV    = 23'd1 << 13,
      S_B_RD    = 23'd1 << 14,
      S_B_EV    = 23'd1 << 15,
      S_CHK     = 23'd1 << 16,
      S_SW1     = 23'd1 << 17,
      S_SW2     = 23'd1 << 18,
      S_NODE_W1 = 23'd1 << 19,
      S_NODE_W2 = 23'd1 << 20,
      S_SP_PUSH = 23'd1 << 21,
      S_SP_END  = 23'd1 << 22
   } state_type;

   // memories
   logic [IW-1:0] item_state_mem [MAX_STATES];
   logic [IW-1:0] state_item_mem [MAX_STATES];
   logic [IW-1:0] item_block_mem [MAX_STATES];
   logic [NW-1:0] block_node_mem [MAX_STATES];
   logic [IW-1:0] node_first_mem [ND];
   logic [IW-1:0] node_last_mem  [ND];

   logic          is_we, si_we, ib_we, bn_we, nf_we, nl_we;
   logic [IW-1:0] is_waddr, is_wdata, is_raddr, is_rdata_ff;
   logic [IW-1:0] si_waddr, si_wdata, si_raddr, si_rdata_ff;
   logic [IW-1:0] ib_waddr, ib_wdata, ib_raddr, ib_rdata_ff;
   logic [IW-1:0] bn_waddr, bn_raddr;
   logic [NW-1:0] bn_wdata, bn_rdata_ff;
   logic [NW-1:0] nf_waddr, nl_waddr, nd_raddr;
   logic [IW-1:0] nf_wdata, nl_wdata, nf_rdata_ff, nl_rdata_ff;

   always_ff @(posedge clock) begin
      if (is_we) item_state_mem[is_waddr] <= is_wdata;
      is_rdata_ff <= item_state_mem[is_raddr];
   end
   always_ff @(posedge clock) begin
      if (si_we) state_item_mem[si_waddr] <= si_wdata;
      si_rdata_ff <= state_item_mem[si_raddr];
   end
   always_ff @(posedge clock) begin
      if (ib_we) item_block_mem[ib_waddr] <= ib_wdata;
      ib_rdata_ff <= item_block_mem[ib_raddr];
   end
   always_ff @(posedge clock) begin
      if (bn_we) block_node_mem[bn_waddr] <= bn_wdata;
      bn_rdata_ff <= block_node_mem[bn_raddr];
   end
   always_ff @(posedge clock) begin
      if (nf_we) node_first_mem[nf_waddr] <= nf_wdata;
      nf_rdata_ff <= node_first_mem[nd_raddr];
   end
   always_ff @(posedge clock) begin
      if (nl_we) node_last_mem[nl_waddr] <= nl_wdata;
      nl_rdata_ff <= node_last_mem[nd_raddr];
   end

   // registers
   state_type          state_ff, state_in;
   pbr_pkg::phase_type phase_ff, phase_in;
   logic [CW-1:0]      ic_ff, ic_in, bc_ff, bc_in;
   logic [NCW-1:0]     nc_ff, nc_in;
   logic [IW-1:0]      open_first_ff, open_first_in;
   logic [MAX_STATES-1:0] loaded_ff, loaded_in, mark_ff, mark_in;
   logic [2:0]         op_ff, op_in;
   logic [5:0]         s_ff, s_in, t_ff, t_in;
   logic               eob_ff, eob_in;
   pbr_pkg::rsp_type   res_ff, res_in;
   logic [CW-1:0]      st_ff, st_in, fin_first_ff, fin_first_in;
   logic [IW-1:0]      q_b1_ff, q_b1_in;
   logic [CW-1:0]      i_ff, i_in, old_bc_ff, old_bc_in;
   logic [5:0]         nres_ff, nres_in;
   logic [NW-1:0]      nd_ff, nd_in;
   logic [IW-1:0]      f0_ff, f0_in, l0_ff, l0_in, k_ff, k_in;
   logic [CW-1:0]      cnt_ff, cnt_in, f_ff, f_in, l_ff, l_in;
   logic               repr_ff, repr_in;
   logic [IW-1:0]      nb_ff, nb_in, vf_ff, vf_in, vl_ff, vl_in;
   logic               pend_v_ff, pend_v_in;
   logic [IW-1:0]      pend_kb_ff, pend_kb_in, pend_nb_ff, pend_nb_in;
   logic [NW-1:0]      pend_an_ff, pend_an_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         phase_ff  <= pbr_pkg::PH_IDLE;
         ic_ff     <= '0;
         bc_ff     <= '0;
         nc_ff     <= '0;
         loaded_ff <= '0;
         mark_ff   <= '0;
         pend_v_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         phase_ff  <= phase_in;
         ic_ff     <= ic_in;
         bc_ff     <= bc_in;
         nc_ff     <= nc_in;
         loaded_ff <= loaded_in;
         mark_ff   <= mark_in;
         pend_v_ff <= pend_v_in;
      end
   end

   always_ff @(posedge clock) begin
      open_first_ff <= open_first_in;
      op_ff         <= op_in;
      s_ff          <= s_in;
      t_ff          <= t_in;
      eob_ff        <= eob_in;
      res_ff        <= res_in;
      st_ff         <= st_in;
      fin_first_ff  <= fin_first_in;
      q_b1_ff       <= q_b1_in;
      i_ff          <= i_in;
      old_bc_ff     <= old_bc_in;
      nres_ff       <= nres_in;
      nd_ff         <= nd_in;
      f0_ff         <= f0_in;
      l0_ff         <= l0_in;
      k_ff          <= k_in;
      cnt_ff        <= cnt_in;
      f_ff          <= f_in;
      l_ff          <= l_in;
      repr_ff       <= repr_in;
      nb_ff         <= nb_in;
      vf_ff         <= vf_in;
      vl_ff         <= vl_in;
      pend_kb_ff    <= pend_kb_in;
      pend_nb_ff    <= pend_nb_in;
      pend_an_ff    <= pend_an_in;
   end

   // state range and validity
   logic [EW-1:0] effn, s_w, t_w, st_w;
   logic [IW-1:0] s_idx, t_idx, st_idx;
   logic          s_in_range, s_valid, t_valid;
   logic          node_room, block_room, item_mark;
   logic [CW-1:0] cnt_next, blk_size;

   assign effn = (EW'(num_states) > EW'(MAX_STATES)) ? EW'(MAX_STATES) : EW'(num_states);
   assign s_w        = EW'(s_ff);
   assign t_w        = EW'(t_ff);
   assign st_w       = EW'(st_ff);
   assign s_idx      = s_w[IW-1:0];
   assign t_idx      = t_w[IW-1:0];
   assign st_idx     = st_ff[IW-1:0];
   assign s_in_range = s_w < effn;
   assign s_valid    = s_in_range && loaded_ff[s_idx];
   assign t_valid    = (t_w < effn) && loaded_ff[t_idx];
   assign node_room  = nc_ff < NCW'(ND);
   assign block_room = bc_ff < CW'(MAX_STATES);
   assign item_mark  = mark_ff[is_rdata_ff];
   assign cnt_next   = cnt_ff + CW'(item_mark);
   assign blk_size   = CW'(l0_ff) - CW'(f0_ff) + CW'(1);

   assign req_stall = (state_ff != S_IDLE);

   pbr_pkg::rsp_type res_blank, res_pend;

   always_comb begin
      res_blank        = '0;
      res_blank.status = pbr_pkg::ST_OK;
      res_blank.last   = 1'b1;
      res_pend               = res_blank;
      res_pend.split_valid   = 1'b1;
      res_pend.kept_block    = 6'(pend_kb_ff);
      res_pend.new_block     = 6'(pend_nb_ff);
      res_pend.ancestor_node = 7'(pend_an_ff);
   end

   always_comb begin
      state_in      = state_ff;
      phase_in      = phase_ff;
      ic_in         = ic_ff;
      bc_in         = bc_ff;
      nc_in         = nc_ff;
      open_first_in = open_first_ff;
      loaded_in     = loaded_ff;
      mark_in       = mark_ff;
      op_in         = op_ff;
      s_in          = s_ff;
      t_in          = t_ff;
      eob_in        = eob_ff;
      res_in        = res_ff;
      st_in         = st_ff;
      fin_first_in  = fin_first_ff;
      q_b1_in       = q_b1_ff;
      i_in          = i_ff;
      old_bc_in     = old_bc_ff;
      nres_in       = nres_ff;
      nd_in         = nd_ff;
      f0_in         = f0_ff;
      l0_in         = l0_ff;
      k_in          = k_ff;
      cnt_in        = cnt_ff;
      f_in          = f_ff;
      l_in          = l_ff;
      repr_in       = repr_ff;
      nb_in         = nb_ff;
      vf_in         = vf_ff;
      vl_in         = vl_ff;
      pend_v_in     = pend_v_ff;
      pend_kb_in    = pend_kb_ff;
      pend_nb_in    = pend_nb_ff;
      pend_an_in    = pend_an_ff;

      is_we = 1'b0; is_waddr = '0; is_wdata = '0; is_raddr = '0;
      si_we = 1'b0; si_waddr = '0; si_wdata = '0; si_raddr = '0;
      ib_we = 1'b0; ib_waddr = '0; ib_wdata = '0; ib_raddr = '0;
      bn_we = 1'b0; bn_waddr = '0; bn_wdata = '0; bn_raddr = '0;
      nf_we = 1'b0; nf_waddr = '0; nf_wdata = '0;
      nl_we = 1'b0; nl_waddr = '0; nl_wdata = '0;
      nd_raddr = '0;

      res_push = 1'b0;
      res_data = res_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in    = req_operation;
               s_in     = req_state_id;
               t_in     = req_other_state_id;
               eob_in   = req_end_of_block;
               state_in = S_DISP;
            end
         end

         S_DISP: begin
            res_in   = res_blank;
            state_in = S_EMIT;
            case (op_ff)
               pbr_pkg::OP_CLEAR: begin
                  ic_in     = '0;
                  bc_in     = '0;
                  nc_in     = '0;
                  phase_in  = pbr_pkg::PH_IDLE;
                  loaded_in = '0;
                  mark_in   = '0;
               end
               pbr_pkg::OP_LOAD: begin
                  if (phase_ff == pbr_pkg::PH_READY) begin
                     res_in.status = pbr_pkg::ST_PHASE;
                  end else if (!s_in_range) begin
                     res_in.status = pbr_pkg::ST_RANGE;
                  end else if (loaded_ff[s_idx]) begin
                     res_in.status = pbr_pkg::ST_DUP;
                  end else if (!(ic_ff < CW'(MAX_STATES)) || !node_room) begin
                     res_in.status = pbr_pkg::ST_RANGE;
                  end else begin
                     if (phase_ff == pbr_pkg::PH_IDLE) open_first_in = ic_ff[IW-1:0];
                     is_we = 1'b1; is_waddr = ic_ff[IW-1:0]; is_wdata = s_idx;
                     si_we = 1'b1; si_waddr = s_idx; si_wdata = ic_ff[IW-1:0];
                     ib_we = 1'b1; ib_waddr = ic_ff[IW-1:0]; ib_wdata = bc_ff[IW-1:0];
                     loaded_in[s_idx] = 1'b1;
                     ic_in = ic_ff + CW'(1);
                     if (eob_ff) begin
                        if (block_room) begin
                           nf_we = 1'b1; nf_waddr = nc_ff[NW-1:0];
                           nf_wdata = (phase_ff == pbr_pkg::PH_IDLE) ? ic_ff[IW-1:0]
                                                                     : open_first_ff;
                           nl_we = 1'b1; nl_waddr = nc_ff[NW-1:0];
                           nl_wdata = ic_ff[IW-1:0];
                           bn_we = 1'b1; bn_waddr = bc_ff[IW-1:0];
                           bn_wdata = nc_ff[NW-1:0];
                           nc_in = nc_ff + NCW'(1);
                           bc_in = bc_ff + CW'(1);
                        end
                        phase_in = pbr_pkg::PH_IDLE;
                     end else begin
                        phase_in = pbr_pkg::PH_OPEN;
                     end
                  end
               end
               pbr_pkg::OP_FINISH: begin
                  if (phase_ff == pbr_pkg::PH_READY) begin
                     res_in.status = pbr_pkg::ST_PHASE;
                  end else begin
                     // close the open initial block first
                     if (phase_ff == pbr_pkg::PH_OPEN && ic_ff != '0 && node_room &&
                         block_room) begin
                        nf_we = 1'b1; nf_waddr = nc_ff[NW-1:0]; nf_wdata = open_first_ff;
                        nl_we = 1'b1; nl_waddr = nc_ff[NW-1:0];
                        nl_wdata = IW'(ic_ff - CW'(1));
                        bn_we = 1'b1; bn_waddr = bc_ff[IW-1:0]; bn_wdata = nc_ff[NW-1:0];
                        nc_in = nc_ff + NCW'(1);
                        bc_in = bc_ff + CW'(1);
                     end
                     fin_first_in = ic_ff;
                     st_in        = '0;
                     state_in     = S_FIN;
                  end
               end
               pbr_pkg::OP_MARK: begin
                  if (phase_ff != pbr_pkg::PH_READY) begin
                     res_in.status = pbr_pkg::ST_PHASE;
                  end else if (!s_valid) begin
                     res_in.status = pbr_pkg::ST_RANGE;
                  end else begin
                     mark_in[s_idx] = 1'b1;
                  end
               end
               pbr_pkg::OP_SPLIT: begin
                  if (phase_ff != pbr_pkg::PH_READY) begin
                     res_in.status = pbr_pkg::ST_PHASE;
                  end else begin
                     i_in      = '0;
                     nres_in   = '0;
                     pend_v_in = 1'b0;
                     old_bc_in = bc_ff;
                     state_in  = S_SP_BLK;
                  end
               end
               pbr_pkg::OP_QUERY: begin
                  if (phase_ff != pbr_pkg::PH_READY) begin
                     res_in.status = pbr_pkg::ST_PHASE;
                  end else if (!s_valid || !t_valid) begin
                     res_in.status = pbr_pkg::ST_RANGE;
                  end else begin
                     si_raddr = s_idx;
                     state_in = S_QA;
                  end
               end
               default: begin
               end
            endcase
         end

         S_EMIT: begin
            if (res_free) begin
               res_push = 1'b1;
               res_data = res_ff;
               state_in = S_IDLE;
            end
         end

         S_FIN: begin
            if (st_w < effn) begin
               if (!loaded_ff[st_idx] && ic_ff < CW'(MAX_STATES)) begin
                  is_we = 1'b1; is_waddr = ic_ff[IW-1:0]; is_wdata = st_idx;
                  si_we = 1'b1; si_waddr = st_idx; si_wdata = ic_ff[IW-1:0];
                  ib_we = 1'b1; ib_waddr = ic_ff[IW-1:0]; ib_wdata = bc_ff[IW-1:0];
                  loaded_in[st_idx] = 1'b1;
                  ic_in = ic_ff + CW'(1);
               end
               st_in = st_ff + CW'(1);
            end else begin
               // gather the unused states into one block
               if (ic_ff > fin_first_ff && node_room && block_room) begin
                  nf_we = 1'b1; nf_waddr = nc_ff[NW-1:0]; nf_wdata = fin_first_ff[IW-1:0];
                  nl_we = 1'b1; nl_waddr = nc_ff[NW-1:0];
                  nl_wdata = IW'(ic_ff - CW'(1));
                  bn_we = 1'b1; bn_waddr = bc_ff[IW-1:0]; bn_wdata = nc_ff[NW-1:0];
                  nc_in = nc_ff + NCW'(1);
                  bc_in = bc_ff + CW'(1);
               end
               phase_in = pbr_pkg::PH_READY;
               state_in = S_EMIT;
            end
         end

         S_QA: begin
            ib_raddr = si_rdata_ff;
            si_raddr = t_idx;
            state_in = S_QB;
         end

         S_QB: begin
            q_b1_in  = ib_rdata_ff;
            ib_raddr = si_rdata_ff;
            state_in = S_QC;
         end

         S_QC: begin
            res_in.block_of_state = 6'(q_b1_ff);
            res_in.block_of_other = 6'(ib_rdata_ff);
            res_in.same_block     = (q_b1_ff == ib_rdata_ff);
            state_in              = S_EMIT;
         end

         S_SP_BLK: begin
            if (i_ff < old_bc_ff && nres_ff < 6'(pbr_pkg::RESULT_CAP)) begin
               bn_raddr = i_ff[IW-1:0];
               state_in = S_SP_NODE;
            end else begin
               state_in = S_SP_END;
            end
         end

         S_SP_NODE: begin
            nd_in    = bn_rdata_ff;
            nd_raddr = bn_rdata_ff;
            state_in = S_SP_RNG;
         end

         S_SP_RNG: begin
            f0_in  = nf_rdata_ff;
            l0_in  = nl_rdata_ff;
            k_in   = nf_rdata_ff;
            cnt_in = '0;
            if (!block_room || (NCW'(nc_ff) + NCW'(2)) > NCW'(ND)) begin
               i_in     = i_ff + CW'(1);
               state_in = S_SP_BLK;
            end else begin
               state_in = S_CNT_RD;
            end
         end

         S_CNT_RD: begin
            is_raddr = k_ff;
            state_in = S_CNT_EV;
         end

         S_CNT_EV: begin
            cnt_in = cnt_next;
            if (k_ff == f0_ff) repr_in = item_mark;
            if (k_ff == l0_ff) begin
               // skip a block that is fully marked or not marked at all
               if (cnt_next == '0 || cnt_next >= blk_size) begin
                  i_in     = i_ff + CW'(1);
                  state_in = S_SP_BLK;
               end else begin
                  f_in     = CW'(f0_ff);
                  l_in     = CW'(l0_ff);
                  nb_in    = bc_ff[IW-1:0];
                  state_in = S_A_RD;
               end
            end else begin
               k_in     = k_ff + IW'(1);
               state_in = S_CNT_RD;
            end
         end

         S_A_RD: begin
            if (f_ff > CW'(l0_ff)) begin
               state_in = S_B_RD;
            end else begin
               is_raddr = f_ff[IW-1:0];
               state_in = S_A_EV;
            end
         end

         S_A_EV: begin
            vf_in = is_rdata_ff;
            if (item_mark == repr_ff) begin
               f_in     = f_ff + CW'(1);
               state_in = S_A_RD;
            end else begin
               state_in = S_B_RD;
            end
         end

         S_B_RD: begin
            if (l_ff < CW'(f0_ff)) begin
               state_in = S_CHK;
            end else begin
               is_raddr = l_ff[IW-1:0];
               state_in = S_B_EV;
            end
         end

         S_B_EV: begin
            vl_in = is_rdata_ff;
            if (item_mark != repr_ff) begin
               ib_we = 1'b1; ib_waddr = l_ff[IW-1:0]; ib_wdata = nb_ff;
               l_in     = l_ff - CW'(1);
               state_in = S_B_RD;
            end else begin
               state_in = S_CHK;
            end
         end

         S_CHK: begin
            state_in = (f_ff > l_ff) ? S_NODE_W1 : S_SW1;
         end

         S_SW1: begin
            is_we = 1'b1; is_waddr = f_ff[IW-1:0]; is_wdata = vl_ff;
            si_we = 1'b1; si_waddr = vl_ff; si_wdata = f_ff[IW-1:0];
            ib_we = 1'b1; ib_waddr = l_ff[IW-1:0]; ib_wdata = nb_ff;
            state_in = S_SW2;
         end

         S_SW2: begin
            is_we = 1'b1; is_waddr = l_ff[IW-1:0]; is_wdata = vf_ff;
            si_we = 1'b1; si_waddr = vf_ff; si_wdata = l_ff[IW-1:0];
            f_in = f_ff + CW'(1);
            l_in = l_ff - CW'(1);
            state_in = ((f_ff + CW'(2)) <= l_ff) ? S_A_RD : S_NODE_W1;
         end

         S_NODE_W1: begin
            nf_we = 1'b1; nf_waddr = nc_ff[NW-1:0]; nf_wdata = f0_ff;
            nl_we = 1'b1; nl_waddr = nc_ff[NW-1:0]; nl_wdata = l_ff[IW-1:0];
            bn_we = 1'b1; bn_waddr = i_ff[IW-1:0]; bn_wdata = nc_ff[NW-1:0];
            state_in = S_NODE_W2;
         end

         S_NODE_W2: begin
            nf_we = 1'b1; nf_waddr = NW'(nc_ff + NCW'(1)); nf_wdata = f_ff[IW-1:0];
            nl_we = 1'b1; nl_waddr = NW'(nc_ff + NCW'(1)); nl_wdata = l0_ff;
            bn_we = 1'b1; bn_waddr = nb_ff; bn_wdata = NW'(nc_ff + NCW'(1));
            nc_in    = nc_ff + NCW'(2);
            bc_in    = bc_ff + CW'(1);
            state_in = S_SP_PUSH;
         end

         S_SP_PUSH: begin
            // the previous split goes out only once it is known not to be last
            if (!pend_v_ff || res_free) begin
               if (pend_v_ff) begin
                  res_push      = 1'b1;
                  res_data      = res_pend;
                  res_data.last = 1'b0;
               end
               pend_v_in  = 1'b1;
               pend_kb_in = i_ff[IW-1:0];
               pend_nb_in = nb_ff;
               pend_an_in = nd_ff;
               nres_in    = nres_ff + 6'd1;
               i_in       = i_ff + CW'(1);
               state_in   = S_SP_BLK;
            end
         end

         S_SP_END: begin
            if (res_free) begin
               res_push  = 1'b1;
               res_data  = pend_v_ff ? res_pend : res_blank;
               mark_in   = '0;
               pend_v_in = 1'b0;
               state_in  = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

[hw/rtl/partition_block_refiner.sv]
// ----------------------------------------------------------------------------
// partition_block_refiner
// Partition refinement over states kept as contiguous item intervals.
// ----------------------------------------------------------------------------
// One item is worked at a time; the next is taken once the previous one has
// handed its last result to the output register. Finish walks the states up
// to num_states (capped at MAX_STATES). A split walks the blocks that exist at
// its start, until RESULT_CAP results are queued: per block it reads the node,
// counts the marks item by item, and for a block that splits scans with the
// two pointers, swaps items, writes the two new nodes and queues the result.
// The item_state memory has a single read port and a single write port. All
// state memories power up unknown and need no clearing pass; clear resets the
// counters and flags.
module partition_block_refiner #(
   parameter int MAX_STATES = pbr_pkg::DEF_MAX_STATES
) (
   input  logic        clock,
   input  logic        reset,
   // input channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_operation,
   input  logic [5:0]  req_state_id,
   input  logic [5:0]  req_other_state_id,
   input  logic        req_end_of_block,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [5:0]  rsp_block_of_state,
   output logic [5:0]  rsp_block_of_other,
   output logic        rsp_same_block,
   output logic        rsp_split_valid,
   output logic [5:0]  rsp_kept_block,
   output logic [5:0]  rsp_new_block,
   output logic [6:0]  rsp_ancestor_node,
   output logic        rsp_last,
   // register port
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   logic [6:0] num_states_ff, num_states_in;
   logic       csr_write;

   // register write on the access cycle of a transfer
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && (paddr[2] == pbr_pkg::REG_NUM_STATES);
   assign num_states_in = csr_write ? pwdata[6:0] : num_states_ff;
   assign prdata    = (paddr[2] == pbr_pkg::REG_NUM_STATES) ? {25'd0, num_states_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_states_ff <= 7'd64;
      end else begin
         num_states_ff <= num_states_in;
      end
   end

   // output register: the sequencer pushes whenever it is empty or draining
   logic             res_push, res_free;
   pbr_pkg::rsp_type res_data;
   logic             rsp_valid_ff, rsp_valid_in;
   pbr_pkg::rsp_type rsp_ff, rsp_in;

   assign res_free     = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid_in = res_push ? 1'b1 : (rsp_stall ? rsp_valid_ff : 1'b0);
   assign rsp_in       = res_push ? res_data : rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_ff.status;
   assign rsp_block_of_state = rsp_ff.block_of_state;
   assign rsp_block_of_other = rsp_ff.block_of_other;
   assign rsp_same_block     = rsp_ff.same_block;
   assign rsp_split_valid    = rsp_ff.split_valid;
   assign rsp_kept_block     = rsp_ff.kept_block;
   assign rsp_new_block      = rsp_ff.new_block;
   assign rsp_ancestor_node  = rsp_ff.ancestor_node;
   assign rsp_last           = rsp_ff.last;

   pbr_ctrl #(
      .MAX_STATES (MAX_STATES)
   ) u_ctrl (
      .clock              (clock),
      .reset              (reset),
      .num_states         (num_states_ff),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_operation      (req_operation),
      .req_state_id       (req_state_id),
      .req_other_state_id (req_other_state_id),
      .req_end_of_block   (req_end_of_block),
      .res_push           (res_push),
      .res_data           (res_data),
      .res_free           (res_free)
   );

endmodule

[dv/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench of the partition block refiner. A directed table, then
// random load / mark / split / query sequences under several num_states
// settings. Every transfer on the input channel runs through an in-bench
// partition predictor, and each result transfer is compared field by field.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int          NODE_DEPTH   = 2 * pbr_pkg::DEF_MAX_STATES - 1;
   localparam int          STALL_LIMIT  = 20000;
   localparam int          HOLD_CYCLES  = 300;
   localparam int          ITEM_TOTAL   = 110;
   localparam logic [2:0]  OP_SPARE_6   = 3'd6;
   localparam logic [2:0]  OP_SPARE_7   = 3'd7;

   // clock, reset and all block inputs start at known values
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [2:0]  req_operation = pbr_pkg::OP_CLEAR;
   logic [5:0]  req_state_id = '0;
   logic [5:0]  req_other_state_id = '0;
   logic        req_end_of_block = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_status;
   logic [5:0]  rsp_block_of_state;
   logic [5:0]  rsp_block_of_other;
   logic        rsp_same_block;
   logic        rsp_split_valid;
   logic [5:0]  rsp_kept_block;
   logic [5:0]  rsp_new_block;
   logic [6:0]  rsp_ancestor_node;
   logic        rsp_last;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [2:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   partition_block_refiner dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Partition predictor: own copy of register, stores and counters
   // ------------------------------------------------------------------------
   int unsigned         num_states_cfg = 64;
   logic [5:0]          part_item_state [pbr_pkg::DEF_MAX_STATES];
   logic [5:0]          part_state_item [pbr_pkg::DEF_MAX_STATES];
   logic [5:0]          part_item_block [pbr_pkg::DEF_MAX_STATES];
   logic [6:0]          part_block_node [pbr_pkg::DEF_MAX_STATES];
   logic [5:0]          part_node_first [NODE_DEPTH];
   logic [5:0]          part_node_last  [NODE_DEPTH];
   bit                  part_loaded     [pbr_pkg::DEF_MAX_STATES];
   bit                  part_marked     [pbr_pkg::DEF_MAX_STATES];
   int                  part_items, part_blocks, part_nodes;
   pbr_pkg::phase_type  part_phase;

   pbr_pkg::rsp_type    expected_rsps[$];
   int                  fail_count = 0;

   // append one result record at the tail of a queue
   function automatic void add_rsp(ref pbr_pkg::rsp_type q[$], input pbr_pkg::rsp_type r);
      q.insert(q.size(), r);
   endfunction

   function automatic void clear_partition();
      foreach (part_loaded[i]) begin
         part_loaded[i] = 0;
         part_marked[i] = 0;
      end
      part_items  = 0;
      part_blocks = 0;
      part_nodes  = 0;
      part_phase  = pbr_pkg::PH_IDLE;
   endfunction

   function automatic int active_states();
      return (num_states_cfg > pbr_pkg::DEF_MAX_STATES) ? pbr_pkg::DEF_MAX_STATES
                                                        : int'(num_states_cfg);
   endfunction

   function automatic bit is_live_state(int s);
      return s < active_states() && part_loaded[s];
   endfunction

   function automatic void append_state(int s);
      part_item_state[part_items] = 6'(s);
      part_state_item[s]          = 6'(part_items);
      part_item_block[part_items] = 6'(part_blocks);
      part_loaded[s]              = 1;
      part_items++;
   endfunction

   function automatic void close_interval(int first, int last);
      if (part_nodes >= NODE_DEPTH || part_blocks >= pbr_pkg::DEF_MAX_STATES) return;
      part_node_first[part_nodes]  = 6'(first);
      part_node_last[part_nodes]   = 6'(last);
      part_block_node[part_blocks] = 7'(part_nodes);
      part_nodes++;
      part_blocks++;
   endfunction

   function automatic bit mark_at(int item);
      return part_marked[part_item_state[item % pbr_pkg::DEF_MAX_STATES]];
   endfunction

   function automatic pbr_pkg::rsp_type status_rsp(logic [1:0] st);
      pbr_pkg::rsp_type r;
      r        = '0;
      r.status = st;
      r.last   = 1'b1;
      return r;
   endfunction

   // Cut each partly marked block, up to RESULT_CAP results, with the two-pointer
   // swap; the representative's side keeps the block index.
   function automatic void refine_blocks(ref pbr_pkg::rsp_type outs[$]);
      int               marked_cnt [pbr_pkg::DEF_MAX_STATES];
      int               old_blocks, f0, l0, f, l, nb, nd;
      bit               repr;
      logic [5:0]       tmp;
      pbr_pkg::rsp_type r;
      foreach (marked_cnt[i]) marked_cnt[i] = 0;
      for (int k = 0; k < part_items; k++)
         if (part_marked[part_item_state[k]]) marked_cnt[part_item_block[k]]++;
      old_blocks = part_blocks;
      for (int i = 0; i < old_blocks && outs.size() < pbr_pkg::RESULT_CAP; i++) begin
         nd = part_block_node[i];
         f0 = part_node_first[nd];
         l0 = part_node_last[nd];
         f  = f0;
         l  = l0;
         nb = part_blocks;
         if (marked_cnt[i] == 0 || l0 < f0 || marked_cnt[i] >= l0 - f0 + 1) continue;
         if (part_blocks >= pbr_pkg::DEF_MAX_STATES || part_nodes + 2 > NODE_DEPTH) continue;
         repr = mark_at(f0);
         do begin
            while (f <= l0 && mark_at(f) == repr) f++;
            while (l >= f0 && mark_at(l) != repr) begin
               part_item_block[l] = 6'(nb);
               l--;
            end
            if (f > l) break;
            tmp                = part_item_state[f];
            part_item_state[f] = part_item_state[l];
            part_item_state[l] = tmp;
            part_state_item[part_item_state[f]] = 6'(f);
            part_state_item[part_item_state[l]] = 6'(l);
            part_item_block[l] = 6'(nb);
            f++;
            l--;
         end while (f <= l);
         part_node_first[part_nodes]     = 6'(f0);
         part_node_last[part_nodes]      = 6'(l);
         part_node_first[part_nodes + 1] = 6'(f);
         part_node_last[part_nodes + 1]  = 6'(l0);
         part_block_node[i]  = 7'(part_nodes);
         part_block_node[nb] = 7'(part_nodes + 1);
         part_nodes += 2;
         part_blocks++;
         r               = '0;
         r.split_valid   = 1'b1;
         r.kept_block    = 6'(i);
         r.new_block     = 6'(nb);
         r.ancestor_node = 7'(nd);
         add_rsp(outs, r);
      end
      foreach (part_marked[i]) part_marked[i] = 0;
      if (outs.size() == 0) add_rsp(outs, status_rsp(pbr_pkg::ST_OK));
      else outs[outs.size() - 1].last = 1'b1;
   endfunction

   function automatic void predict_step(logic [2:0] op, logic [5:0] s, logic [5:0] t,
                                        logic eob, ref pbr_pkg::rsp_type outs[$]);
      pbr_pkg::rsp_type r;
      int               first;
      outs.delete();
      case (op)
         pbr_pkg::OP_CLEAR: begin
            clear_partition();
            add_rsp(outs, status_rsp(pbr_pkg::ST_OK));
         end
         pbr_pkg::OP_LOAD: begin
            if (part_phase == pbr_pkg::PH_READY) add_rsp(outs, status_rsp(pbr_pkg::ST_PHASE));
            else if (s >= active_states()) add_rsp(outs, status_rsp(pbr_pkg::ST_RANGE));
            else if (part_loaded[s]) add_rsp(outs, status_rsp(pbr_pkg::ST_DUP));
            else if (part_items >= pbr_pkg::DEF_MAX_STATES || part_nodes >= NODE_DEPTH)
               add_rsp(outs, status_rsp(pbr_pkg::ST_RANGE));
            else begin
               if (part_phase == pbr_pkg::PH_IDLE) begin
                  part_node_first[part_nodes] = 6'(part_items);
                  part_phase = pbr_pkg::PH_OPEN;
               end
               append_state(s);
               if (eob) begin
                  close_interval(part_node_first[part_nodes], part_items - 1);
                  part_phase = pbr_pkg::PH_IDLE;
               end
               add_rsp(outs, status_rsp(pbr_pkg::ST_OK));
            end
         end
         pbr_pkg::OP_FINISH: begin
            if (part_phase == pbr_pkg::PH_READY) add_rsp(outs, status_rsp(pbr_pkg::ST_PHASE));
            else begin
               if (part_phase == pbr_pkg::PH_OPEN && part_items > 0)
                  close_interval(part_node_first[part_nodes], part_items - 1);
               first = part_items;
               for (int st = 0; st < active_states(); st++)
                  if (!part_loaded[st]) append_state(st);
               if (part_items > first) close_interval(first, part_items - 1);
               part_phase = pbr_pkg::PH_READY;
               add_rsp(outs, status_rsp(pbr_pkg::ST_OK));
            end
         end
         pbr_pkg::OP_MARK: begin
            if (part_phase != pbr_pkg::PH_READY) add_rsp(outs, status_rsp(pbr_pkg::ST_PHASE));
            else if (!is_live_state(s)) add_rsp(outs, status_rsp(pbr_pkg::ST_RANGE));
            else begin
               part_marked[s] = 1;
               add_rsp(outs, status_rsp(pbr_pkg::ST_OK));
            end
         end
         pbr_pkg::OP_SPLIT: begin
            if (part_phase != pbr_pkg::PH_READY) add_rsp(outs, status_rsp(pbr_pkg::ST_PHASE));
            else refine_blocks(outs);
         end
         pbr_pkg::OP_QUERY: begin
            if (part_phase != pbr_pkg::PH_READY) add_rsp(outs, status_rsp(pbr_pkg::ST_PHASE));
            else if (!is_live_state(s) || !is_live_state(t))
               add_rsp(outs, status_rsp(pbr_pkg::ST_RANGE));
            else begin
               r                = status_rsp(pbr_pkg::ST_OK);
               r.block_of_state = part_item_block[part_state_item[s]];
               r.block_of_other = part_item_block[part_state_item[t]];
               r.same_block     = (r.block_of_state == r.block_of_other);
               add_rsp(outs, r);
            end
         end
         default: add_rsp(outs, status_rsp(pbr_pkg::ST_OK));
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // Traffic shaping: idle percentages per mode and one long receiver hold
   // ------------------------------------------------------------------------
   int unsigned req_idle_pct = 15;
   int unsigned rsp_idle_pct = 61;
   int          items_sent = 0;
   bit          hold_request = 0;
   bit          hold_done = 0;
   int          hold_left = 0;

   // receiver: random stall, or hold it high for a long stretch once
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_request && !hold_done) begin
         rsp_stall <= 1'b1;
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
      end
   end

   function automatic void compare_field(string name, logic [6:0] exp_v, logic [6:0] act_v);
      if (exp_v != act_v) begin
         $error("%s: expected %0d, got %0d", name, exp_v, act_v);
         fail_count++;
      end
   endfunction

   // check every result transfer against the oldest expectation
   always @(posedge clock) begin
      pbr_pkg::rsp_type exp_r;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsps.size() == 0) begin
            $error("result transfer with no expectation pending");
            fail_count++;
         end else begin
            exp_r = expected_rsps.pop_front();
            compare_field("status", 7'(exp_r.status), 7'(rsp_status));
            compare_field("block_of_state", 7'(exp_r.block_of_state),
                          7'(rsp_block_of_state));
            compare_field("block_of_other", 7'(exp_r.block_of_other),
                          7'(rsp_block_of_other));
            compare_field("same_block", 7'(exp_r.same_block), 7'(rsp_same_block));
            compare_field("split_valid", 7'(exp_r.split_valid), 7'(rsp_split_valid));
            compare_field("kept_block", 7'(exp_r.kept_block), 7'(rsp_kept_block));
            compare_field("new_block", 7'(exp_r.new_block), 7'(rsp_new_block));
            compare_field("ancestor_node", exp_r.ancestor_node, rsp_ancestor_node);
            compare_field("last", 7'(exp_r.last), 7'(rsp_last));
         end
      end
   end

   // watchdog: end the run after too long without any transfer
   int quiet_cycles = 0;
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (psel && penable && pwrite))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Driving tasks
   // ------------------------------------------------------------------------
   // Send one item; expectations come from the predictor, or from the
   // literal status when the row gives one.
   task automatic send_op(logic [2:0] op, logic [5:0] s, logic [5:0] t, logic eob,
                          bit literal = 0, logic [1:0] lit_status = pbr_pkg::ST_OK);
      pbr_pkg::rsp_type outs[$];
      predict_step(op, s, t, eob, outs);
      if (literal) add_rsp(expected_rsps, status_rsp(lit_status));
      else foreach (outs[i]) add_rsp(expected_rsps, outs[i]);
      items_sent++;
      // mode change: sender light/receiver heavy, then swapped, then none
      if (items_sent == 40) begin
         req_idle_pct = 61;
         rsp_idle_pct = 15;
      end else if (items_sent == 75) begin
         req_idle_pct = 0;
         rsp_idle_pct = 0;
      end
      if (items_sent == 70) hold_request <= 1;
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_operation      <= op;
      req_state_id       <= s;
      req_other_state_id <= t;
      req_end_of_block   <= eob;
      do @(posedge clock); while (req_stall);
   endtask

   // Send one random-phase item while the item budget lasts.
   task automatic send_random(logic [2:0] op, logic [5:0] s, logic [5:0] t, logic eob);
      if (items_sent < ITEM_TOTAL) send_op(op, s, t, eob);
   endtask

   // Write num_states once the block has drained.
   task automatic write_num_states(logic [6:0] value);
      req_valid <= 1'b0;
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= 3'(4 * pbr_pkg::REG_NUM_STATES);
      pwdata  <= 32'(value);
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      num_states_cfg = 32'(value);
   endtask

   // ------------------------------------------------------------------------
   // Directed table
   // ------------------------------------------------------------------------
   typedef struct {
      bit         is_cfg;
      logic [6:0] cfg_value;
      logic [2:0] op;
      logic [5:0] s;
      logic [5:0] t;
      logic       eob;
      bit         literal;
      logic [1:0] lit_status;
   } dir_row_type;

   dir_row_type dir_rows [31] = '{
      '{0, 0, pbr_pkg::OP_QUERY,   0,  0,  0, 1, pbr_pkg::ST_PHASE},  // nothing loaded yet
      '{0, 0, pbr_pkg::OP_MARK,    0,  0,  0, 1, pbr_pkg::ST_PHASE},
      '{0, 0, pbr_pkg::OP_SPLIT,   0,  0,  0, 1, pbr_pkg::ST_PHASE},
      '{0, 0, pbr_pkg::OP_LOAD,    63, 0,  0, 1, pbr_pkg::ST_OK},     // top state, open
      '{0, 0, pbr_pkg::OP_LOAD,    63, 0,  1, 1, pbr_pkg::ST_DUP},
      '{0, 0, pbr_pkg::OP_LOAD,    0,  0,  1, 1, pbr_pkg::ST_OK},
      '{0, 0, pbr_pkg::OP_LOAD,    5,  0,  0, 0, pbr_pkg::ST_OK},
      '{0, 0, pbr_pkg::OP_LOAD,    20, 0,  1, 0, pbr_pkg::ST_OK},
      '{0, 0, OP_SPARE_6,          0,  0,  0, 1, pbr_pkg::ST_OK},     // unknown codes
      '{0, 0, OP_SPARE_7,          63, 63, 1, 1, pbr_pkg::ST_OK},
      '{0, 0, pbr_pkg::OP_FINISH,  0,  0,  0, 1, pbr_pkg::ST_OK},     // rest in one block
      '{0, 0, pbr_pkg::OP_FINISH,  0,  0,  0, 1, pbr_pkg::ST_PHASE},
      '{0, 0, pbr_pkg::OP_LOAD,    1,  0,  0, 1, pbr_pkg::ST_PHASE},
      '{0, 0, pbr_pkg::OP_QUERY,   63, 0,  0, 0, pbr_pkg::ST_OK},
      '{0, 0, pbr_pkg::OP_MARK,    63, 0,  0, 0, pbr_pkg::ST_OK},
      '{0, 0, pbr_pkg::OP_MARK,    5,  0,  0, 0, pbr_pkg::ST_OK},
      '{0, 0, pbr_pkg::OP_MARK,    33, 0,  0, 0, pbr_pkg::ST_OK},
      '{0, 0, pbr_pkg::OP_SPLIT,   0,  0,  0, 0, pbr_pkg::ST_OK},
      '{0, 0, pbr_pkg::OP_SPLIT,   0,  0,  0, 0, pbr_pkg::ST_OK},     // marks gone
      '{0, 0, pbr_pkg::OP_QUERY,   5,  63, 0, 0, pbr_pkg::ST_OK},
      '{0, 0, pbr_pkg::OP_CLEAR,   0,  0,  0, 1, pbr_pkg::ST_OK},
      '{1, 1, pbr_pkg::OP_CLEAR,   0,  0,  0, 0, pbr_pkg::ST_OK},     // one state only
      '{0, 0, pbr_pkg::OP_LOAD,    1,  0,  0, 1, pbr_pkg::ST_RANGE},
      '{0, 0, pbr_pkg::OP_LOAD,    0,  0,  0, 1, pbr_pkg::ST_OK},
      '{0, 0, pbr_pkg::OP_FINISH,  0,  0,  0, 1, pbr_pkg::ST_OK},     // open block closed
      '{0, 0, pbr_pkg::OP_QUERY,   0,  0,  0, 0, pbr_pkg::ST_OK},
      '{0, 0, pbr_pkg::OP_QUERY,   0,  1,  0, 1, pbr_pkg::ST_RANGE},
      '{0, 0, pbr_pkg::OP_MARK,    0,  0,  0, 0, pbr_pkg::ST_OK},
      '{0, 0, pbr_pkg::OP_SPLIT,   0,  0,  0, 0, pbr_pkg::ST_OK},     // never cut
      '{1, 127, pbr_pkg::OP_CLEAR, 0,  0,  0, 0, pbr_pkg::ST_OK},     // acts as 64
      '{0, 0, pbr_pkg::OP_CLEAR,   0,  0,  0, 1, pbr_pkg::ST_OK}
   };

   // ------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------
   initial begin
      int order[$];
      int n, j, tmp;
      clear_partition();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[i]) begin
         if (dir_rows[i].is_cfg) write_num_states(dir_rows[i].cfg_value);
         else send_op(dir_rows[i].op, dir_rows[i].s, dir_rows[i].t, dir_rows[i].eob,
                      dir_rows[i].literal, dir_rows[i].lit_status);
      end

      // random rounds: optional register change, load, finish, refine cycles
      while (items_sent < ITEM_TOTAL) begin
         if ($urandom_range(2) == 0) begin
            case ($urandom_range(5))
               0:       write_num_states(7'd64);
               1:       write_num_states(7'd127);
               default: write_num_states(7'($urandom_range(1, 16)));
            endcase
         end
         send_random(pbr_pkg::OP_CLEAR, 6'($urandom), 6'($urandom), 1'($urandom));
         n = active_states();
         order.delete();
         for (int i = 0; i < n; i++) order.insert(order.size(), i);
         for (int i = n - 1; i > 0; i--) begin
            j        = $urandom_range(i);
            tmp      = order[i];
            order[i] = order[j];
            order[j] = tmp;
         end
         foreach (order[i]) begin
            if ($urandom_range(9) == 0)
               send_random(pbr_pkg::OP_LOAD, 6'($urandom), 6'($urandom), 1'($urandom));
            if ($urandom_range(99) < 85)
               send_random(pbr_pkg::OP_LOAD, 6'(order[i]), 6'($urandom),
                           $urandom_range(3) == 0);
         end
         send_random(pbr_pkg::OP_FINISH, 6'($urandom), 6'($urandom), 1'($urandom));
         repeat ($urandom_range(1, 4)) begin
            repeat ($urandom_range(1, n)) begin
               if ($urandom_range(9) == 0)
                  send_random(pbr_pkg::OP_MARK, 6'($urandom), 6'($urandom), 1'($urandom));
               else
                  send_random(pbr_pkg::OP_MARK, 6'($urandom_range(n - 1)), 6'($urandom),
                              1'($urandom));
            end
            send_random(pbr_pkg::OP_SPLIT, 6'($urandom), 6'($urandom), 1'($urandom));
            repeat ($urandom_range(1, 3)) begin
               if ($urandom_range(9) == 0)
                  send_random(pbr_pkg::OP_QUERY, 6'($urandom), 6'($urandom), 1'($urandom));
               else
                  send_random(pbr_pkg::OP_QUERY, 6'($urandom_range(n - 1)),
                              6'($urandom_range(n - 1)), 1'($urandom));
            end
         end
      end

      // drain, then let the block settle before the verdict
      req_valid <= 1'b0;
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (fail_count == 0 && expected_rsps.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
